### rtl/ctfc_pkg.sv
// Package: shared types, field positions and prescaler table for the clock tree calculator.
package ctfc_pkg;

    // Field widths
    localparam int OSC_W     = 26;
    localparam int WORD_W    = 32;
    localparam int M_W       = 6;
    localparam int N_W       = 9;
    localparam int SH_W      = 4;
    localparam int CFG_IDX_W = 2;

    // Divider layout: dividend padded to a multiple of the bits per stage
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = (OSC_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W      = DIV_STAGES * DIV_BITS;

    // Product of quotient and N
    localparam int VCO_W = OSC_W + N_W;

    // Reciprocal of three for a 32-bit dividend: x / 3 = (x * RECIP3) >> 33
    localparam logic [WORD_W-1:0] RECIP3       = 32'hAAAA_AAAB;
    localparam int                RECIP3_SHIFT = 33;
    localparam int                HALF_W       = WORD_W - 1;
    localparam int                PROD3_W      = HALF_W + WORD_W;

    // Switch status codes (clock_config_word bits 3:2)
    localparam logic [1:0] SWS_INTERNAL = 2'd0;
    localparam logic [1:0] SWS_EXTERNAL = 2'd1;
    localparam logic [1:0] SWS_PLL      = 2'd2;

    // PLL output divider codes
    localparam logic [1:0] PDIV_2 = 2'd0;
    localparam logic [1:0] PDIV_4 = 2'd1;
    localparam logic [1:0] PDIV_6 = 2'd2;
    localparam logic [1:0] PDIV_8 = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXTERNAL_OSC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERNAL_OSC = 2'd1;

    localparam logic [OSC_W-1:0] EXTERNAL_OSC_RESET = 26'd25_000_000;
    localparam logic [OSC_W-1:0] INTERNAL_OSC_RESET = 26'd16_000_000;

    // Bit positions in the configuration words
    localparam int PLL_M_LSB   = 0;
    localparam int PLL_N_LSB   = 6;
    localparam int PLL_P_LSB   = 16;
    localparam int PLL_SRC_BIT = 22;
    localparam int SWS_LSB     = 2;
    localparam int AHB_LSB     = 4;
    localparam int APB1_LSB    = 10;
    localparam int APB2_LSB    = 13;

    // Control fields that ride along with each item
    typedef struct packed {
        logic             sel_pll;
        logic             bad;
        logic [1:0]       pcode;
        logic [SH_W-1:0]  ahb_sh;
        logic [SH_W-1:0]  apb1_sh;
        logic [SH_W-1:0]  apb2_sh;
        logic [OSC_W-1:0] src;
    } ctl_t;

    // One divider stage: dividend bits shift out on top, quotient bits in at the bottom
    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [M_W-1:0]   rem;
        logic [M_W-1:0]   m;
        logic [N_W-1:0]   n;
        ctl_t             ctl;
    } div_t;

    // Prescaler code to shift amount
    function automatic logic [SH_W-1:0] presc_shift(input logic [3:0] code);
        logic [SH_W-1:0] sh;
        unique case (code)
            4'd4, 4'd8:   sh = 4'd1;
            4'd5, 4'd9:   sh = 4'd2;
            4'd6, 4'd10:  sh = 4'd3;
            4'd7, 4'd11:  sh = 4'd4;
            4'd12:        sh = 4'd6;
            4'd13:        sh = 4'd7;
            4'd14:        sh = 4'd8;
            4'd15:        sh = 4'd9;
            default:      sh = 4'd0;
        endcase
        return sh;
    endfunction

    // AHB codes below eight mean not divided
    function automatic logic [SH_W-1:0] ahb_shift(input logic [3:0] code);
        logic [SH_W-1:0] sh;
        sh = code[3] ? presc_shift(code) : '0;
        return sh;
    endfunction

    function automatic logic [SH_W-1:0] apb_shift(input logic [2:0] code);
        logic [SH_W-1:0] sh;
        sh = presc_shift({1'b0, code});
        return sh;
    endfunction

    // Several restoring division steps on a narrow remainder
    function automatic div_t div_step(input div_t d);
        div_t            r;
        logic [M_W:0]    trial;
        logic            qbit;
        r = d;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {r.rem, r.num[DIV_W-1]};
            qbit  = (trial >= {1'b0, r.m});
            if (qbit) begin
                trial = trial - {1'b0, r.m};
            end
            r.rem = trial[M_W-1:0];
            r.num = {r.num[DIV_W-2:0], qbit};
        end
        return r;
    endfunction

endpackage

### rtl/clock_tree_frequency_calc_unit.sv
// Top level: pipelined clock tree frequency calculator (divide, multiply, scale, prescale).
//
//  channel | signals                                          | beat moves
//  --------+--------------------------------------------------+----------------------------
//  in      | in_valid, in_ready, pll_config_word,             | one pair of config words
//          | clock_config_word                                |
//  out     | out_valid, out_ready, sysclk_hz, hclk_hz,        | one set of clock frequencies
//          | pclk1_hz, pclk2_hz, bad_divider, overflow        |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data        | one oscillator register write
//
// One beat enters per cycle unless a stall at the output backs up to the input.
// Seven stages of the source / M divider (four quotient bits each) set the depth,
// followed by the N multiply, the divide by P, the AHB shift and the APB shifts.
// Each stage holds its beat while the next one is full and stalled; empty stages
// still take new beats while a finished result waits at the output.
// Reset empties the pipeline and loads the oscillator registers with their defaults.
module clock_tree_frequency_calc_unit
    import ctfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [WORD_W-1:0]    pll_config_word,
    input  logic [WORD_W-1:0]    clock_config_word,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_W-1:0]    sysclk_hz,
    output logic [WORD_W-1:0]    hclk_hz,
    output logic [WORD_W-1:0]    pclk1_hz,
    output logic [WORD_W-1:0]    pclk2_hz,
    output logic                 bad_divider,
    output logic                 overflow,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    localparam int MUL_STG = DIV_STAGES;
    localparam int SCL_STG = DIV_STAGES + 1;
    localparam int AHB_STG = DIV_STAGES + 2;
    localparam int OUT_STG = DIV_STAGES + 3;
    localparam int NSTG    = DIV_STAGES + 4;

    logic [OSC_W-1:0] ext_osc_reg;
    logic [OSC_W-1:0] int_osc_reg;

    logic [NSTG-1:0]  valid_reg;
    logic [NSTG-1:0]  rdy;

    div_t             entry;
    div_t             div_reg [DIV_STAGES];

    // Multiply stage
    ctl_t             mul_ctl_reg;
    logic [VCO_W-1:0] vco_reg;

    // Scale stage
    ctl_t               scl_ctl_reg;
    logic               scl_ovf_reg;
    logic [PROD3_W-1:0] prod3_reg;
    logic [WORD_W-1:0]  shr_reg;
    logic               vco_ovf;
    logic [WORD_W-1:0]  vco_sat;
    logic [WORD_W-1:0]  shr_next;

    // AHB stage
    ctl_t              ahb_ctl_reg;
    logic [WORD_W-1:0] sys_reg;
    logic [WORD_W-1:0] hclk_reg;
    logic              bad_reg;
    logic              ovf_reg;
    logic [WORD_W-1:0] sys_next;
    logic [WORD_W-1:0] pll_out;

    // Output stage
    logic [WORD_W-1:0] o_sys_reg;
    logic [WORD_W-1:0] o_hclk_reg;
    logic [WORD_W-1:0] o_p1_reg;
    logic [WORD_W-1:0] o_p2_reg;
    logic              o_bad_reg;
    logic              o_ovf_reg;

    // Oscillator registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_osc_reg <= EXTERNAL_OSC_RESET;
            int_osc_reg <= INTERNAL_OSC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_EXTERNAL_OSC)
            begin
                ext_osc_reg <= cfg_data[OSC_W-1:0];
            end
            else if (cfg_index == REG_INTERNAL_OSC)
            begin
                int_osc_reg <= cfg_data[OSC_W-1:0];
            end
        end
    end

    // Stage handshake: a stage takes a beat when empty or when its own beat moves on
    assign rdy[NSTG-1] = !valid_reg[NSTG-1] || out_ready;

    for (genvar k = 0; k < NSTG - 1; k++)
    begin : g_rdy
        assign rdy[k] = !valid_reg[k] || rdy[k+1];
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Decode the input beat and pick the source frequency
    always_comb
    begin
        logic [1:0] sws;
        sws = clock_config_word[SWS_LSB +: 2];
        entry.ctl.sel_pll = (sws == SWS_PLL);
        entry.m           = pll_config_word[PLL_M_LSB +: M_W];
        entry.n           = pll_config_word[PLL_N_LSB +: N_W];
        entry.ctl.pcode   = pll_config_word[PLL_P_LSB +: 2];
        entry.ctl.bad     = entry.ctl.sel_pll && (entry.m == '0);
        entry.ctl.ahb_sh  = ahb_shift(clock_config_word[AHB_LSB +: 4]);
        entry.ctl.apb1_sh = apb_shift(clock_config_word[APB1_LSB +: 3]);
        entry.ctl.apb2_sh = apb_shift(clock_config_word[APB2_LSB +: 3]);
        if (entry.ctl.sel_pll)
        begin
            entry.ctl.src = pll_config_word[PLL_SRC_BIT] ? ext_osc_reg : int_osc_reg;
        end
        else if (sws == SWS_EXTERNAL)
        begin
            entry.ctl.src = ext_osc_reg;
        end
        else
        begin
            entry.ctl.src = int_osc_reg;
        end
        entry.num = {{(DIV_W - OSC_W){1'b0}}, entry.ctl.src};
        entry.rem = '0;
    end

    // Divider stages: advance four quotient bits per stage
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (rdy[k])
                begin
                    div_reg[k] <= div_step(entry);
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (rdy[k])
                begin
                    div_reg[k] <= div_step(div_reg[k-1]);
                end
            end
        end
    end

    // Multiply the quotient by N
    always_ff @(posedge clk)
    begin
        if (rdy[MUL_STG])
        begin
            mul_ctl_reg <= div_reg[DIV_STAGES-1].ctl;
            vco_reg     <= VCO_W'(div_reg[DIV_STAGES-1].num[OSC_W-1:0])
                         * VCO_W'(div_reg[DIV_STAGES-1].n);
        end
    end

    // Saturate, then divide by P: shifts for powers of two, reciprocal multiply for six
    always_comb
    begin
        vco_ovf = |vco_reg[VCO_W-1:WORD_W];
        vco_sat = vco_ovf ? '1 : vco_reg[WORD_W-1:0];
        unique case (mul_ctl_reg.pcode)
            PDIV_2:  shr_next = vco_sat >> 1;
            PDIV_4:  shr_next = vco_sat >> 2;
            PDIV_8:  shr_next = vco_sat >> 3;
            default: shr_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[SCL_STG])
        begin
            scl_ctl_reg <= mul_ctl_reg;
            scl_ovf_reg <= vco_ovf;
            shr_reg     <= shr_next;
            prod3_reg   <= PROD3_W'(vco_sat[WORD_W-1:1]) * PROD3_W'(RECIP3);
        end
    end

    // Select the system clock and apply the AHB prescaler
    always_comb
    begin
        if (scl_ctl_reg.pcode == PDIV_6)
        begin
            pll_out = WORD_W'(prod3_reg[PROD3_W-1:RECIP3_SHIFT]);
        end
        else
        begin
            pll_out = shr_reg;
        end

        if (scl_ctl_reg.bad)
        begin
            sys_next = '0;
        end
        else if (scl_ctl_reg.sel_pll)
        begin
            sys_next = pll_out;
        end
        else
        begin
            sys_next = WORD_W'(scl_ctl_reg.src);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[AHB_STG])
        begin
            ahb_ctl_reg <= scl_ctl_reg;
            sys_reg     <= sys_next;
            hclk_reg    <= sys_next >> scl_ctl_reg.ahb_sh;
            bad_reg     <= scl_ctl_reg.bad;
            ovf_reg     <= scl_ctl_reg.sel_pll && !scl_ctl_reg.bad && scl_ovf_reg;
        end
    end

    // Apply the APB prescalers and hold the result beat
    always_ff @(posedge clk)
    begin
        if (rdy[OUT_STG])
        begin
            o_sys_reg  <= sys_reg;
            o_hclk_reg <= hclk_reg;
            o_p1_reg   <= hclk_reg >> ahb_ctl_reg.apb1_sh;
            o_p2_reg   <= hclk_reg >> ahb_ctl_reg.apb2_sh;
            o_bad_reg  <= bad_reg;
            o_ovf_reg  <= ovf_reg;
        end
    end

    assign out_valid   = valid_reg[NSTG-1];
    assign sysclk_hz   = o_sys_reg;
    assign hclk_hz     = o_hclk_reg;
    assign pclk1_hz    = o_p1_reg;
    assign pclk2_hz    = o_p2_reg;
    assign bad_divider = o_bad_reg;
    assign overflow    = o_ovf_reg;

endmodule

### verif/tb_top.sv
// Testbench for the clock tree frequency calculator: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import ctfc_pkg::*;

    // Switch status code 3 falls back to the internal oscillator
    localparam logic [1:0] SWS_INTERNAL_ALT = 2'd3;
    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int DIRECTED_ROWS = 25;
    localparam int PHASE_ITEMS   = 300;

    // Prescaler shift per 4-bit code, code 0 in the low nibble
    localparam logic [63:0] SHIFT_LUT = {4'd9, 4'd8, 4'd7, 4'd6, 4'd4, 4'd3, 4'd2, 4'd1,
                                         4'd4, 4'd3, 4'd2, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0};

    typedef struct packed {
        logic [WORD_W-1:0] sys;
        logic [WORD_W-1:0] hclk;
        logic [WORD_W-1:0] pclk1;
        logic [WORD_W-1:0] pclk2;
        logic              bad;
        logic              ovf;
    } clocks_t;

    typedef struct packed {
        logic [WORD_W-1:0] pll;
        logic [WORD_W-1:0] cfg;
        logic              known;
        clocks_t           clocks;
    } stim_row_t;

    localparam clocks_t NO_CLOCKS = '0;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [WORD_W-1:0]    pll_config_word;
    logic [WORD_W-1:0]    clock_config_word;
    logic                 out_valid;
    logic                 out_ready;
    logic [WORD_W-1:0]    sysclk_hz;
    logic [WORD_W-1:0]    hclk_hz;
    logic [WORD_W-1:0]    pclk1_hz;
    logic [WORD_W-1:0]    pclk2_hz;
    logic                 bad_divider;
    logic                 overflow;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    // Oscillator registers as the block should hold them
    logic [OSC_W-1:0] ext_osc_hz;
    logic [OSC_W-1:0] int_osc_hz;

    clocks_t   expected_clocks[$];
    stim_row_t directed_rows[DIRECTED_ROWS];
    int        mismatches;
    int        send_idle_pct;
    int        recv_stall_pct;

    clock_tree_frequency_calc_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .pll_config_word   (pll_config_word),
        .clock_config_word (clock_config_word),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .sysclk_hz         (sysclk_hz),
        .hclk_hz           (hclk_hz),
        .pclk1_hz          (pclk1_hz),
        .pclk2_hz          (pclk2_hz),
        .bad_divider       (bad_divider),
        .overflow          (overflow),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Fail the run if it hangs
    initial
    begin
        #(20_000_000);
        $display("clock_tree_frequency_calc_unit verification failed");
        $finish;
    end

    function automatic logic [3:0] shift_for_code(input logic [3:0] code);
        return SHIFT_LUT[{code, 2'b00} +: 4];
    endfunction

    function automatic logic [WORD_W-1:0] make_pll(input logic [5:0] m, input logic [8:0] n,
                                                   input logic [1:0] pcode, input logic src);
        return {9'b0, src, 4'b0, pcode, 1'b0, n, m};
    endfunction

    function automatic logic [WORD_W-1:0] make_cfg(input logic [1:0] sws, input logic [3:0] ahb,
                                                   input logic [2:0] apb1, input logic [2:0] apb2);
        return {16'b0, apb2, apb1, 2'b0, ahb, sws, 2'b0};
    endfunction

    function automatic clocks_t fixed_clocks(input logic [WORD_W-1:0] sys,
                                             input logic [WORD_W-1:0] hclk,
                                             input logic [WORD_W-1:0] pclk1,
                                             input logic [WORD_W-1:0] pclk2,
                                             input logic bad, input logic ovf);
        clocks_t c;
        c = '{sys, hclk, pclk1, pclk2, bad, ovf};
        return c;
    endfunction

    // Work out the four bus clocks and flags for one pair of config words
    function automatic clocks_t calc_clocks(input logic [WORD_W-1:0] pll,
                                            input logic [WORD_W-1:0] cfg);
        clocks_t          c;
        logic [M_W-1:0]   m;
        logic [N_W-1:0]   n;
        logic [3:0]       pdiv;
        logic [OSC_W-1:0] src;
        logic [63:0]      vco;
        logic [3:0]       ahb_sh;
        c    = NO_CLOCKS;
        m    = pll[PLL_M_LSB +: M_W];
        n    = pll[PLL_N_LSB +: N_W];
        pdiv = ({2'b00, pll[PLL_P_LSB +: 2]} + 4'd1) << 1;
        src  = pll[PLL_SRC_BIT] ? ext_osc_hz : int_osc_hz;
        case (cfg[SWS_LSB +: 2])
            SWS_PLL:
            begin
                if (m == '0)
                begin
                    c.bad = 1'b1;
                end
                else
                begin
                    vco = 64'(src) / 64'(m);
                    vco = vco * 64'(n);
                    // saturate the product before the divide by P
                    if (vco > 64'hFFFF_FFFF)
                    begin
                        vco   = 64'hFFFF_FFFF;
                        c.ovf = 1'b1;
                    end
                    c.sys = vco[WORD_W-1:0] / 32'(pdiv);
                end
            end
            SWS_EXTERNAL: c.sys = 32'(ext_osc_hz);
            default:      c.sys = 32'(int_osc_hz);
        endcase
        if (!c.bad)
        begin
            ahb_sh  = cfg[AHB_LSB + 3] ? shift_for_code(cfg[AHB_LSB +: 4]) : 4'd0;
            c.hclk  = c.sys >> ahb_sh;
            c.pclk1 = c.hclk >> shift_for_code({1'b0, cfg[APB1_LSB +: 3]});
            c.pclk2 = c.hclk >> shift_for_code({1'b0, cfg[APB2_LSB +: 3]});
        end
        return c;
    endfunction

    task automatic note_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Compare one output beat against the oldest expectation
    task automatic check_result();
        clocks_t want;
        if (expected_clocks.size() == 0)
        begin
            note_mismatch("result with nothing pending, sysclk_hz", sysclk_hz, '0);
        end
        else
        begin
            want = expected_clocks.pop_front();
            if (sysclk_hz !== want.sys)     note_mismatch("sysclk_hz", sysclk_hz, want.sys);
            if (hclk_hz !== want.hclk)      note_mismatch("hclk_hz", hclk_hz, want.hclk);
            if (pclk1_hz !== want.pclk1)    note_mismatch("pclk1_hz", pclk1_hz, want.pclk1);
            if (pclk2_hz !== want.pclk2)    note_mismatch("pclk2_hz", pclk2_hz, want.pclk2);
            if (bad_divider !== want.bad)   note_mismatch("bad_divider", 32'(bad_divider),
                                                          32'(want.bad));
            if (overflow !== want.ovf)      note_mismatch("overflow", 32'(overflow),
                                                          32'(want.ovf));
        end
    endtask

    // Drive one input beat; hold it until accepted, then log what it should produce
    task automatic send_item(input logic [WORD_W-1:0] pll, input logic [WORD_W-1:0] cfg,
                             input logic typed, input clocks_t typed_clocks);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        pll_config_word   <= pll;
        clock_config_word <= cfg;
        do
            @(posedge clk);
        while (!in_ready);
        expected_clocks.push_back(typed ? typed_clocks : calc_clocks(pll, cfg));
    endtask

    // Drop valid and wait for every pending result
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_clocks.size() != 0);
    endtask

    task automatic write_osc(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_EXTERNAL_OSC)
            ext_osc_hz = data[OSC_W-1:0];
        else if (idx == REG_INTERNAL_OSC)
            int_osc_hz = data[OSC_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Oscillator value with junk in the bits above the register
    function automatic logic [WORD_W-1:0] osc_word(input logic [OSC_W-1:0] hz);
        return {6'($urandom_range(63)), hz};
    endfunction

    // Mostly PLL selections with a usable M, some fixed sources, the rest raw noise
    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        logic [WORD_W-1:0] pll;
        logic [WORD_W-1:0] cfg;
        int                pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            pll  = $urandom();
            cfg  = $urandom();
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                cfg[SWS_LSB +: 2] = SWS_PLL;
                if ($urandom_range(3) == 0)
                    pll[PLL_M_LSB +: M_W] = 6'($urandom_range(4, 1));
                else if (pll[PLL_M_LSB +: M_W] == '0 && $urandom_range(9) != 0)
                    pll[PLL_M_LSB +: M_W] = 6'($urandom_range(63, 1));
            end
            else if (pick < 80)
            begin
                cfg[SWS_LSB +: 2] = ($urandom_range(1) != 0) ? SWS_EXTERNAL : SWS_INTERNAL;
            end
            send_item(pll, cfg, 1'b0, NO_CLOCKS);
        end
    endtask

    // Output side: check accepted beats, stall at the phase rate
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_result();
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ext_osc_hz     = EXTERNAL_OSC_RESET;
        int_osc_hz     = INTERNAL_OSC_RESET;

        in_valid          <= 1'b0;
        pll_config_word   <= '0;
        clock_config_word <= '0;
        cfg_valid         <= 1'b0;
        cfg_index         <= REG_EXTERNAL_OSC;
        cfg_data          <= '0;
        rst_n             <= 1'b0;

        // Directed table; known rows assume the reset oscillator values
        directed_rows[0]  = '{make_pll(6'd0, 9'd0, PDIV_2, 1'b0),
                              make_cfg(SWS_INTERNAL, 4'd0, 3'd0, 3'd0), 1'b1,
                              fixed_clocks(32'd16_000_000, 32'd16_000_000, 32'd16_000_000,
                                           32'd16_000_000, 1'b0, 1'b0)};
        directed_rows[1]  = '{make_pll(6'd0, 9'd0, PDIV_2, 1'b0),
                              make_cfg(SWS_EXTERNAL, 4'd0, 3'd0, 3'd0), 1'b1,
                              fixed_clocks(32'd25_000_000, 32'd25_000_000, 32'd25_000_000,
                                           32'd25_000_000, 1'b0, 1'b0)};
        directed_rows[2]  = '{make_pll(6'd0, 9'd0, PDIV_2, 1'b0),
                              make_cfg(SWS_INTERNAL_ALT, 4'd0, 3'd0, 3'd0), 1'b1,
                              fixed_clocks(32'd16_000_000, 32'd16_000_000, 32'd16_000_000,
                                           32'd16_000_000, 1'b0, 1'b0)};
        // PLL with a zero input divider
        directed_rows[3]  = '{make_pll(6'd0, 9'd511, PDIV_8, 1'b1),
                              make_cfg(SWS_PLL, 4'd15, 3'd7, 3'd7), 1'b1,
                              fixed_clocks('0, '0, '0, '0, 1'b1, 1'b0)};
        directed_rows[4]  = '{32'hFFFF_FFC0, 32'hFFFF_FFFB, 1'b1,
                              fixed_clocks('0, '0, '0, '0, 1'b1, 1'b0)};
        // All ones: internal source with the deepest prescalers
        directed_rows[5]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                              fixed_clocks(32'd16_000_000, 32'd31_250, 32'd1_953, 32'd1_953,
                                           1'b0, 1'b0)};
        // Saturated product
        directed_rows[6]  = '{make_pll(6'd1, 9'd511, PDIV_2, 1'b1),
                              make_cfg(SWS_PLL, 4'd0, 3'd0, 3'd0), 1'b1,
                              fixed_clocks(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           32'h7FFF_FFFF, 1'b0, 1'b1)};
        directed_rows[7]  = '{make_pll(6'd1, 9'd511, PDIV_8, 1'b1),
                              make_cfg(SWS_PLL, 4'd0, 3'd0, 3'd0), 1'b1,
                              fixed_clocks(32'h1FFF_FFFF, 32'h1FFF_FFFF, 32'h1FFF_FFFF,
                                           32'h1FFF_FFFF, 1'b0, 1'b1)};
        // N of zero gives a stopped PLL
        directed_rows[8]  = '{make_pll(6'd4, 9'd0, PDIV_2, 1'b0),
                              make_cfg(SWS_PLL, 4'd0, 3'd0, 3'd0), 1'b1, NO_CLOCKS};
        // Walk every AHB code, every APB code and every P code
        directed_rows[9]  = '{make_pll(6'd25, 9'd336, PDIV_2, 1'b1),
                              make_cfg(SWS_PLL, 4'd0, 3'd0, 3'd7), 1'b0, NO_CLOCKS};
        directed_rows[10] = '{make_pll(6'd8, 9'd192, PDIV_4, 1'b0),
                              make_cfg(SWS_PLL, 4'd1, 3'd1, 3'd6), 1'b0, NO_CLOCKS};
        directed_rows[11] = '{make_pll(6'd12, 9'd360, PDIV_6, 1'b1),
                              make_cfg(SWS_PLL, 4'd2, 3'd2, 3'd5), 1'b0, NO_CLOCKS};
        directed_rows[12] = '{make_pll(6'd63, 9'd511, PDIV_8, 1'b0),
                              make_cfg(SWS_PLL, 4'd3, 3'd3, 3'd4), 1'b0, NO_CLOCKS};
        directed_rows[13] = '{make_pll(6'd2, 9'd100, PDIV_2, 1'b0),
                              make_cfg(SWS_EXTERNAL, 4'd4, 3'd4, 3'd3), 1'b0, NO_CLOCKS};
        directed_rows[14] = '{make_pll(6'd1, 9'd300, PDIV_4, 1'b1),
                              make_cfg(SWS_PLL, 4'd5, 3'd5, 3'd2), 1'b0, NO_CLOCKS};
        directed_rows[15] = '{make_pll(6'd16, 9'd2, PDIV_6, 1'b0),
                              make_cfg(SWS_PLL, 4'd6, 3'd6, 3'd1), 1'b0, NO_CLOCKS};
        directed_rows[16] = '{make_pll(6'd5, 9'd1, PDIV_8, 1'b1),
                              make_cfg(SWS_PLL, 4'd7, 3'd7, 3'd0), 1'b0, NO_CLOCKS};
        directed_rows[17] = '{make_pll(6'd25, 9'd432, PDIV_6, 1'b1),
                              make_cfg(SWS_PLL, 4'd8, 3'd0, 3'd4), 1'b0, NO_CLOCKS};
        directed_rows[18] = '{make_pll(6'd4, 9'd168, PDIV_8, 1'b0),
                              make_cfg(SWS_INTERNAL, 4'd9, 3'd4, 3'd0), 1'b0, NO_CLOCKS};
        directed_rows[19] = '{make_pll(6'd25, 9'd400, PDIV_4, 1'b1),
                              make_cfg(SWS_PLL, 4'd10, 3'd5, 3'd6), 1'b0, NO_CLOCKS};
        directed_rows[20] = '{make_pll(6'd3, 9'd511, PDIV_2, 1'b0),
                              make_cfg(SWS_PLL, 4'd11, 3'd6, 3'd5), 1'b0, NO_CLOCKS};
        directed_rows[21] = '{make_pll(6'd10, 9'd50, PDIV_2, 1'b1),
                              make_cfg(SWS_INTERNAL_ALT, 4'd12, 3'd7, 3'd7), 1'b0, NO_CLOCKS};
        directed_rows[22] = '{make_pll(6'd7, 9'd255, PDIV_6, 1'b1),
                              make_cfg(SWS_PLL, 4'd13, 3'd4, 3'd5), 1'b0, NO_CLOCKS};
        // Product just under the saturation point
        directed_rows[23] = '{make_pll(6'd1, 9'd256, PDIV_8, 1'b0),
                              make_cfg(SWS_PLL, 4'd14, 3'd2, 3'd6), 1'b0, NO_CLOCKS};
        directed_rows[24] = '{make_pll(6'd9, 9'd99, PDIV_4, 1'b1),
                              make_cfg(SWS_EXTERNAL, 4'd15, 3'd3, 3'd1), 1'b0, NO_CLOCKS};

        // Hold reset, then release it
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(directed_rows[i].pll, directed_rows[i].cfg,
                      directed_rows[i].known, directed_rows[i].clocks);

        // Reset oscillators, back-to-back beats
        run_random(PHASE_ITEMS, 0, 0);
        drain();

        // Slow crystal with junk high bits, fastest RC; sparse sender
        write_osc(REG_EXTERNAL_OSC, osc_word(26'd4_000_000));
        write_osc(REG_INTERNAL_OSC, 32'(26'd64_000_000));
        run_random(PHASE_ITEMS, 88, 0);
        drain();

        // Fastest crystal, slowest RC, writes to the spare indexes; stalling receiver
        write_osc(REG_EXTERNAL_OSC, 32'(26'd50_000_000));
        write_osc(REG_INTERNAL_OSC, osc_word(26'd1_000_000));
        write_osc(REG_SPARE_2, 32'hFFFF_FFFF);
        write_osc(REG_SPARE_3, 32'h5A5A_A5A5);
        run_random(PHASE_ITEMS, 0, 88);
        drain();

        // Random in-range oscillators; both sides idle now and then
        write_osc(REG_EXTERNAL_OSC, osc_word(26'($urandom_range(50_000_000, 4_000_000))));
        write_osc(REG_INTERNAL_OSC, osc_word(26'($urandom_range(64_000_000, 1_000_000))));
        run_random(PHASE_ITEMS, 24, 24);
        drain();

        write_osc(REG_INTERNAL_OSC, osc_word(26'($urandom_range(64_000_000, 1_000_000))));
        write_osc(REG_EXTERNAL_OSC, osc_word(26'($urandom_range(50_000_000, 4_000_000))));
        run_random(PHASE_ITEMS, 0, 0);
        drain();

        // Back to the reset values
        write_osc(REG_EXTERNAL_OSC, osc_word(EXTERNAL_OSC_RESET));
        write_osc(REG_INTERNAL_OSC, osc_word(INTERNAL_OSC_RESET));
        run_random(PHASE_ITEMS, 24, 24);
        drain();

        // Let any stray beat show up before the verdict
        repeat (24) @(posedge clk);
        if (mismatches == 0)
            $display("clock_tree_frequency_calc_unit verification clean");
        else
            $display("clock_tree_frequency_calc_unit verification failed");
        $finish;
    end

endmodule

### clock_tree_frequency_calc_unit.f
rtl/ctfc_pkg.sv
rtl/clock_tree_frequency_calc_unit.sv
verif/tb_top.sv
